// ===== rtl/fea_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fea_pkg
// Shared types, codes and helper functions of the element-wise float ALU.
// ----------------------------------------------------------------------------
package fea_pkg;

  // Width of the signed working exponents
  localparam int EW = 13;
  typedef logic signed [EW-1:0] exp_t;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam logic [31:0] INF  = 32'h7F80_0000;

  // Operators
  typedef enum logic [1:0] {
    OP_SUB = 2'd0,
    OP_ADD = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Element types
  typedef enum logic [3:0] {
    TY_S8  = 4'd0,
    TY_U8  = 4'd1,
    TY_S16 = 4'd2,
    TY_U16 = 4'd3,
    TY_S32 = 4'd4,
    TY_U32 = 4'd5,
    TY_S64 = 4'd6,
    TY_U64 = 4'd7,
    TY_F32 = 4'd8,
    TY_F64 = 4'd9
  } elem_type_e;

  // Register indexes
  localparam logic [1:0] REG_OP     = 2'd0;
  localparam logic [1:0] REG_TYPE_A = 2'd1;
  localparam logic [1:0] REG_TYPE_B = 2'd2;

  // Pipeline control travelling with each request
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  // Unrounded value sign * mant * 2^expo, plus sticky, or a ready special
  typedef struct packed {
    logic        sign;
    logic [63:0] mant;
    exp_t        expo;
    logic        sticky;
    logic        spec;
    logic [31:0] spec_bits;
  } norm_t;

  // Leading zero count, 64 when the word is zero
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fea_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fea_norm
// Three-stage normalise and round to single precision, nearest even:
// leading zero count, normalising shift, then denormal shift and rounding.
// ----------------------------------------------------------------------------
module fea_norm (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire fea_pkg::ctl_t  ctl_i,
  input  wire fea_pkg::norm_t req_i,
  output fea_pkg::ctl_t       ctl_o,
  output logic [31:0]         res_o
);

  // Stage 1: leading zero count
  fea_pkg::ctl_t  c1_q, c2_q, c3_q;
  logic           sign1_q, stk1_q, spec1_q;
  logic [63:0]    mant1_q;
  fea_pkg::exp_t  e1_q;
  logic [6:0]     lz1_q;
  logic [31:0]    specb1_q;

  // Stage 2: normalised mantissa and shift amount
  logic           sign2_q, stk2_q, spec2_q, zero2_q, big2_q;
  logic [63:0]    mn2_q;
  logic [6:0]     sh2_q;
  logic [7:0]     ebias2_q;
  logic [31:0]    specb2_q;

  logic [31:0]    res3_q;

  fea_pkg::exp_t  e_top, shw;
  logic [63:0]    mn;
  logic           normal, big;
  logic [6:0]     sh;
  logic [7:0]     ebias;

  logic [127:0]   ext;
  logic [23:0]    mant;
  logic           guard, rest, up;
  logic [31:0]    sum, fin, res;

  // Exponent of the leading one and the right shift to the result grid
  always_comb begin
    e_top  = fea_pkg::exp_t'(e1_q + fea_pkg::exp_t'(63) - fea_pkg::exp_t'({6'b0, lz1_q}));
    mn     = mant1_q << lz1_q[5:0];
    normal = (e_top >= fea_pkg::exp_t'(-126));
    big    = (e_top > fea_pkg::exp_t'(127));
    shw    = fea_pkg::exp_t'(fea_pkg::exp_t'(-86) - e_top);
    if (normal) begin
      sh = 7'd40;
    end else if (e_top < fea_pkg::exp_t'(-213)) begin
      sh = 7'd127;
    end else begin
      sh = shw[6:0];
    end
    ebias = normal ? 8'(e_top + fea_pkg::exp_t'(126)) : 8'd0;
  end

  // Round to nearest even; a carry into the exponent is natural
  always_comb begin
    ext   = {mn2_q, 64'b0} >> sh2_q;
    mant  = ext[87:64];
    guard = ext[63];
    rest  = (|ext[62:0]) | stk2_q;
    up    = guard & (rest | mant[0]);
    sum   = {1'b0, ebias2_q, 23'b0} + {7'b0, ({1'b0, mant} + {24'b0, up})};
    fin   = (sum >= fea_pkg::INF) ? fea_pkg::INF : sum;
    if (spec2_q) begin
      res = specb2_q;
    end else if (zero2_q) begin
      res = {sign2_q, 31'b0};
    end else if (big2_q) begin
      res = {sign2_q, fea_pkg::INF[30:0]};
    end else begin
      res = {sign2_q, fin[30:0]};
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
    end else if (en_i) begin
      c1_q <= ctl_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sign1_q  <= req_i.sign;
      mant1_q  <= req_i.mant;
      e1_q     <= req_i.expo;
      stk1_q   <= req_i.sticky;
      spec1_q  <= req_i.spec;
      specb1_q <= req_i.spec_bits;
      lz1_q    <= fea_pkg::lzc64(req_i.mant);

      sign2_q  <= sign1_q;
      stk2_q   <= stk1_q;
      spec2_q  <= spec1_q;
      specb2_q <= specb1_q;
      zero2_q  <= lz1_q[6];
      big2_q   <= big;
      mn2_q    <= mn;
      sh2_q    <= sh;
      ebias2_q <= ebias;

      res3_q   <= res;
    end
  end

  assign ctl_o = c3_q;
  assign res_o = res3_q;

endmodule
`default_nettype wire

// ===== rtl/fea_cvt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fea_cvt
// Operand conversion to single precision: unpack of integer or float64
// elements into sign, magnitude and exponent, then the shared rounder.
// ----------------------------------------------------------------------------
module fea_cvt (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire fea_pkg::ctl_t ctl_i,
  input  wire logic [63:0]  raw_i,
  input  wire logic [3:0]   type_i,
  output fea_pkg::ctl_t      ctl_o,
  output logic [31:0]        f32_o
);

  fea_pkg::ctl_t  c0_q;
  fea_pkg::norm_t req_q;
  fea_pkg::norm_t req;

  logic [63:0] x;
  logic        neg, is_int;
  logic [10:0] ex;
  logic [51:0] frac;

  // Unpack by element type
  always_comb begin
    x      = '0;
    neg    = 1'b0;
    is_int = 1'b1;
    ex     = raw_i[62:52];
    frac   = raw_i[51:0];
    req    = '0;
    case (type_i)
      fea_pkg::TY_S8:  begin x = {{56{raw_i[7]}}, raw_i[7:0]};   neg = raw_i[7];  end
      fea_pkg::TY_U8:  begin x = {56'b0, raw_i[7:0]};                            end
      fea_pkg::TY_S16: begin x = {{48{raw_i[15]}}, raw_i[15:0]}; neg = raw_i[15]; end
      fea_pkg::TY_U16: begin x = {48'b0, raw_i[15:0]};                           end
      fea_pkg::TY_S32: begin x = {{32{raw_i[31]}}, raw_i[31:0]}; neg = raw_i[31]; end
      fea_pkg::TY_U32: begin x = {32'b0, raw_i[31:0]};                           end
      fea_pkg::TY_S64: begin x = raw_i;                          neg = raw_i[63]; end
      fea_pkg::TY_U64: begin x = raw_i;                                          end
      fea_pkg::TY_F32: begin
        is_int        = 1'b0;
        req.spec      = 1'b1;
        req.spec_bits = raw_i[31:0];
      end
      fea_pkg::TY_F64: begin
        is_int   = 1'b0;
        req.sign = raw_i[63];
        if (ex == 11'h7FF) begin
          req.spec      = 1'b1;
          req.spec_bits = (frac != 52'b0) ? fea_pkg::QNAN
                                          : {raw_i[63], fea_pkg::INF[30:0]};
        end else if (ex == 11'h000) begin
          req.mant = {12'b0, frac};
          req.expo = fea_pkg::exp_t'(-1074);
        end else begin
          req.mant = {11'b0, 1'b1, frac};
          req.expo = fea_pkg::exp_t'(fea_pkg::exp_t'({2'b0, ex}) - fea_pkg::exp_t'(1075));
        end
      end
      default: begin
        // unused codes read as +0
        is_int   = 1'b0;
        req.spec = 1'b1;
      end
    endcase
    if (is_int) begin
      req.sign = neg;
      req.mant = neg ? (~x + 64'd1) : x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
    end else if (en_i) begin
      c0_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_q <= req;
    end
  end

  fea_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .ctl_i  (c0_q),
    .req_i  (req_q),
    .ctl_o  (ctl_o),
    .res_o  (f32_o)
  );

endmodule
`default_nettype wire

// ===== rtl/fea_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fea_alu
// Five-stage single precision arithmetic core: unpack and special cases, then
// add/sub alignment, 24x24 multiply, or a restoring divider at seven quotient
// bits per stage, six in the last. Output is an unrounded value for fea_norm.
// ----------------------------------------------------------------------------
module fea_alu (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire fea_pkg::ctl_t  ctl_i,
  input  wire logic [31:0]    a_i,
  input  wire logic [31:0]    b_i,
  input  wire fea_pkg::op_e   op_i,
  output fea_pkg::ctl_t       ctl_o,
  output fea_pkg::norm_t      req_o
);

  typedef struct packed {
    logic          sign;
    fea_pkg::exp_t expo;
    logic [23:0]   mant;
    logic          zero;
    logic          inf;
    logic          nan;
  } unp_t;

  // Split an f32 word; subnormals come out normalised
  function automatic unp_t unpack(input logic [31:0] f);
    unp_t        u;
    logic [23:0] m;
    logic [4:0]  lz;
    m      = {1'b0, f[22:0]};
    lz     = fea_pkg::lzc24(m);
    u.sign = f[31];
    u.zero = (f[30:0] == 31'b0);
    u.inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'b0);
    u.nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'b0);
    if (f[30:23] == 8'h00) begin
      u.mant = m << lz;
      u.expo = fea_pkg::exp_t'(fea_pkg::exp_t'(-126) - fea_pkg::exp_t'({8'b0, lz}));
    end else begin
      u.mant = {1'b1, f[22:0]};
      u.expo = fea_pkg::exp_t'(fea_pkg::exp_t'({5'b0, f[30:23]}) - fea_pkg::exp_t'(127));
    end
    return u;
  endfunction

  // n restoring division steps: returns {remainder, quotient}
  function automatic logic [52:0] div_run(input logic [25:0] r_in, input logic [26:0] q_in,
                                          input logic [23:0] d, input int n);
    logic [25:0] r;
    logic [26:0] q;
    r = r_in;
    q = q_in;
    for (int i = 0; i < n; i++) begin
      if (r >= {2'b0, d}) begin
        r = r - {2'b0, d};
        q = {q[25:0], 1'b1};
      end else begin
        q = {q[25:0], 1'b0};
      end
      r = {r[24:0], 1'b0};
    end
    return {r, q};
  endfunction

  // ---- stage 1: unpack and special results
  fea_pkg::ctl_t c1_q, c2_q, c3_q, c4_q, c5_q;
  fea_pkg::op_e  op1_q, op2_q, op3_q, op4_q;
  logic          spec1_q, spec2_q, spec3_q, spec4_q;
  logic [31:0]   specb1_q, specb2_q, specb3_q, specb4_q;
  unp_t          a1_q, b1_q;
  logic          bse1_q;

  unp_t          ua, ub;
  logic          bse, sx0, spec;
  logic [31:0]   specb;

  always_comb begin
    ua    = unpack(a_i);
    ub    = unpack(b_i);
    bse   = b_i[31] ^ (op_i == fea_pkg::OP_SUB);
    sx0   = a_i[31] ^ b_i[31];
    spec  = 1'b1;
    specb = fea_pkg::QNAN;
    case (op_i)
      fea_pkg::OP_SUB, fea_pkg::OP_ADD: begin
        if (ua.nan || ub.nan) begin
          specb = fea_pkg::QNAN;
        end else if (ua.inf && ub.inf && (ua.sign != bse)) begin
          specb = fea_pkg::QNAN;
        end else if (ua.inf) begin
          specb = {ua.sign, fea_pkg::INF[30:0]};
        end else if (ub.inf) begin
          specb = {bse, fea_pkg::INF[30:0]};
        end else if (ua.zero && ub.zero) begin
          specb = {ua.sign & bse, 31'b0};
        end else if (ua.zero) begin
          specb = {bse, b_i[30:0]};
        end else if (ub.zero) begin
          specb = a_i;
        end else begin
          spec = 1'b0;
        end
      end
      fea_pkg::OP_MUL: begin
        if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
          specb = fea_pkg::QNAN;
        end else if (ua.inf || ub.inf) begin
          specb = {sx0, fea_pkg::INF[30:0]};
        end else if (ua.zero || ub.zero) begin
          specb = {sx0, 31'b0};
        end else begin
          spec = 1'b0;
        end
      end
      default: begin
        // division; any zero divisor gives the quiet NaN
        if (ub.zero || ua.nan || ub.nan || (ua.inf && ub.inf)) begin
          specb = fea_pkg::QNAN;
        end else if (ua.inf) begin
          specb = {sx0, fea_pkg::INF[30:0]};
        end else if (ub.inf || ua.zero) begin
          specb = {sx0, 31'b0};
        end else begin
          spec = 1'b0;
        end
      end
    endcase
  end

  // ---- stage 2: order by magnitude, multiply, first divider steps
  logic          sign2_q, esub2_q;
  fea_pkg::exp_t ex2_q;
  logic [23:0]   mbig2_q, msml2_q, dvs2_q;
  logic [4:0]    dcap2_q;
  logic [47:0]   prod2_q;
  logic [25:0]   r2_q;
  logic [26:0]   q2_q;

  logic          abig, sx, sign2;
  fea_pkg::exp_t dexp, ex2;
  logic [4:0]    dcap;
  logic [52:0]   dv2;

  always_comb begin
    abig = (a1_q.expo > b1_q.expo) ||
           ((a1_q.expo == b1_q.expo) && (a1_q.mant >= b1_q.mant));
    dexp = abig ? fea_pkg::exp_t'(a1_q.expo - b1_q.expo)
                : fea_pkg::exp_t'(b1_q.expo - a1_q.expo);
    dcap = (dexp > fea_pkg::exp_t'(31)) ? 5'd31 : dexp[4:0];
    sx   = a1_q.sign ^ b1_q.sign;
    case (op1_q)
      fea_pkg::OP_SUB, fea_pkg::OP_ADD: begin
        sign2 = abig ? a1_q.sign : bse1_q;
        ex2   = fea_pkg::exp_t'((abig ? a1_q.expo : b1_q.expo) - fea_pkg::exp_t'(26));
      end
      fea_pkg::OP_MUL: begin
        sign2 = sx;
        ex2   = fea_pkg::exp_t'(a1_q.expo + b1_q.expo - fea_pkg::exp_t'(46));
      end
      default: begin
        sign2 = sx;
        ex2   = fea_pkg::exp_t'(a1_q.expo - b1_q.expo - fea_pkg::exp_t'(26));
      end
    endcase
    dv2 = div_run({2'b0, a1_q.mant}, 27'b0, b1_q.mant, 7);
  end

  // ---- stage 3: alignment with sticky, divider steps
  logic          sign3_q, esub3_q;
  fea_pkg::exp_t ex3_q;
  logic [26:0]   big3_q, al3_q;
  logic [23:0]   dvs3_q;
  logic [47:0]   prod3_q;
  logic [25:0]   r3_q;
  logic [26:0]   q3_q;

  logic [58:0]   wide;
  logic [26:0]   al;
  logic [52:0]   dv3;

  always_comb begin
    wide = {msml2_q, 3'b0, 32'b0} >> dcap2_q;
    al   = wide[58:32] | {26'b0, |wide[31:0]};
    dv3  = div_run(r2_q, q2_q, dvs2_q, 7);
  end

  // ---- stage 4: add or subtract, divider steps
  logic          sign4_q;
  fea_pkg::exp_t ex4_q;
  logic [27:0]   sum4_q;
  logic [23:0]   dvs4_q;
  logic [47:0]   prod4_q;
  logic [25:0]   r4_q;
  logic [26:0]   q4_q;

  logic [27:0]   sum;
  logic          is_add3, sign4;
  logic [52:0]   dv4;

  always_comb begin
    sum     = esub3_q ? ({1'b0, big3_q} - {1'b0, al3_q}) : ({1'b0, big3_q} + {1'b0, al3_q});
    is_add3 = (op3_q == fea_pkg::OP_ADD) || (op3_q == fea_pkg::OP_SUB);
    // exact cancellation gives +0
    sign4   = (is_add3 && (sum == 28'b0)) ? 1'b0 : sign3_q;
    dv4     = div_run(r3_q, q3_q, dvs3_q, 7);
  end

  // ---- stage 5: last divider steps and result select
  fea_pkg::norm_t req5_q;
  fea_pkg::norm_t req5;
  logic [52:0]    dv5;

  always_comb begin
    dv5            = div_run(r4_q, q4_q, dvs4_q, 6);
    req5.sign      = sign4_q;
    req5.expo      = ex4_q;
    req5.spec      = spec4_q;
    req5.spec_bits = specb4_q;
    req5.sticky    = 1'b0;
    case (op4_q)
      fea_pkg::OP_SUB, fea_pkg::OP_ADD: req5.mant = {36'b0, sum4_q};
      fea_pkg::OP_MUL:                  req5.mant = {16'b0, prod4_q};
      default: begin
        req5.mant   = {37'b0, dv5[26:0]};
        req5.sticky = (dv5[52:27] != 26'b0);
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
    end else if (en_i) begin
      c1_q <= ctl_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
      c5_q <= c4_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q    <= op_i;
      spec1_q  <= spec;
      specb1_q <= specb;
      a1_q     <= ua;
      b1_q     <= ub;
      bse1_q   <= bse;

      op2_q    <= op1_q;
      spec2_q  <= spec1_q;
      specb2_q <= specb1_q;
      sign2_q  <= sign2;
      esub2_q  <= a1_q.sign ^ bse1_q;
      ex2_q    <= ex2;
      mbig2_q  <= abig ? a1_q.mant : b1_q.mant;
      msml2_q  <= abig ? b1_q.mant : a1_q.mant;
      dcap2_q  <= dcap;
      prod2_q  <= a1_q.mant * b1_q.mant;
      dvs2_q   <= b1_q.mant;
      r2_q     <= dv2[52:27];
      q2_q     <= dv2[26:0];

      op3_q    <= op2_q;
      spec3_q  <= spec2_q;
      specb3_q <= specb2_q;
      sign3_q  <= sign2_q;
      esub3_q  <= esub2_q;
      ex3_q    <= ex2_q;
      big3_q   <= {mbig2_q, 3'b0};
      al3_q    <= al;
      prod3_q  <= prod2_q;
      dvs3_q   <= dvs2_q;
      r3_q     <= dv3[52:27];
      q3_q     <= dv3[26:0];

      op4_q    <= op3_q;
      spec4_q  <= spec3_q;
      specb4_q <= specb3_q;
      sign4_q  <= sign4;
      ex4_q    <= ex3_q;
      sum4_q   <= sum;
      prod4_q  <= prod3_q;
      dvs4_q   <= dvs3_q;
      r4_q     <= dv4[52:27];
      q4_q     <= dv4[26:0];

      req5_q   <= req5;
    end
  end

  assign ctl_o = c5_q;
  assign req_o = req5_q;

endmodule
`default_nettype wire

// ===== rtl/float_elementwise_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// float_elementwise_alu: element-wise A op B in single precision.
// Conversion, arithmetic and round stages; one request per cycle unless the
// output stalls, which freezes the whole pipeline; the last round stage is
// the output register. Reset clears valid bits, op_mode to 0, types to f32.
// ----------------------------------------------------------------------------
module float_elementwise_alu (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [3:0]   cfg_data_i,
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // [63:0] a_bits, [127:64] b_bits
  input  wire logic         s_axis_tlast,   // last_element
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [31:0] result_bits
  output logic              m_axis_tlast    // last_out
);

  fea_pkg::op_e   op_q;
  logic [3:0]     type_a_q, type_b_q;

  fea_pkg::ctl_t  in_ctl, cvt_a_ctl, cvt_b_ctl, alu_ctl, out_ctl;
  logic [31:0]    a_f32, b_f32, res;
  fea_pkg::norm_t alu_req;
  logic           en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= fea_pkg::OP_SUB;
      type_a_q <= fea_pkg::TY_F32;
      type_b_q <= fea_pkg::TY_F32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fea_pkg::REG_OP:     op_q     <= fea_pkg::op_e'(cfg_data_i[1:0]);
        fea_pkg::REG_TYPE_A: type_a_q <= cfg_data_i;
        fea_pkg::REG_TYPE_B: type_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a result is held back
  assign en            = !out_ctl.valid || m_axis_tready;
  assign s_axis_tready = en;
  assign in_ctl        = '{valid: s_axis_tvalid, last: s_axis_tlast};

  fea_cvt u_cvt_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (in_ctl),
    .raw_i  (s_axis_tdata[63:0]),
    .type_i (type_a_q),
    .ctl_o  (cvt_a_ctl),
    .f32_o  (a_f32)
  );

  fea_cvt u_cvt_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (in_ctl),
    .raw_i  (s_axis_tdata[127:64]),
    .type_i (type_b_q),
    .ctl_o  (cvt_b_ctl),
    .f32_o  (b_f32)
  );

  fea_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (cvt_a_ctl),
    .a_i    (a_f32),
    .b_i    (b_f32),
    .op_i   (op_q),
    .ctl_o  (alu_ctl),
    .req_o  (alu_req)
  );

  fea_norm u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (alu_ctl),
    .req_i  (alu_req),
    .ctl_o  (out_ctl),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_ctl.valid;
  assign m_axis_tlast  = out_ctl.last;
  assign m_axis_tdata  = res;

  // Both converters must stay in lock step
  a_cvt_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cvt_a_ctl == cvt_b_ctl)
    else $error("operand converters out of step");

  // Every NaN leaving the block is the canonical quiet NaN
  a_canon_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[30:23] == 8'hFF) && (m_axis_tdata[22:0] != 23'b0))
    |-> (m_axis_tdata == fea_pkg::QNAN))
    else $error("non-canonical NaN on output");

  // A held result blocks new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

endmodule
`default_nettype wire
